// File: rtl/frp_pkg.sv
`timescale 1ns / 1ps

package frp_pkg;

	localparam int BUFFER_BYTES_DEF  = 256;
	localparam int IDX_W             = 5;
	localparam int ID_W              = 3;
	localparam int FIRST_FRAME_BYTES = 6;
	localparam int NEXT_FRAME_BYTES  = 7;
	localparam int WORD_BYTES        = 8;

	typedef logic [7:0]     octet_t;
	typedef logic [IDX_W-1:0] frame_idx_t;
	typedef logic [ID_W-1:0]  seq_id_t;

endpackage

// File: rtl/fast_packet_reassembler.sv
`timescale 1ns / 1ps

// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------------
// frame in | start / busy        | header_byte, data_byte_1 .. data_byte_7
// word out | word_strobe (1 clk) | word_data, word_bytes, packet_length, last_word
//
// A frame is taken when start is high and busy is low. The frame's payload bytes are
// written to the packet buffer one per cycle (6 or 7 bytes), so busy stays high while
// they are stored after the transfer; a frame that is ignored does not raise busy.
// On completion the buffer is read one 8-byte row per cycle: words leave one per cycle,
// ceil(len/8) of them (one for an empty packet), the first once the state has entered emit
// and its row read is registered. Reset clears all control state; the buffer is not cleared.
// The receiver cannot stall: each word is on the ports for exactly one cycle.

module fast_packet_reassembler #(
	parameter int BUFFER_BYTES = frp_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  header_byte,
	input  logic [7:0]  data_byte_1,
	input  logic [7:0]  data_byte_2,
	input  logic [7:0]  data_byte_3,
	input  logic [7:0]  data_byte_4,
	input  logic [7:0]  data_byte_5,
	input  logic [7:0]  data_byte_6,
	input  logic [7:0]  data_byte_7,
	output logic        word_strobe,
	output logic [63:0] word_data,
	output logic [3:0]  word_bytes,
	output logic [7:0]  packet_length,
	output logic        last_word
);

	localparam int ROWS   = (BUFFER_BYTES + frp_pkg::WORD_BYTES - 1) / frp_pkg::WORD_BYTES;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [8:0] BUF_LIM = 9'(BUFFER_BYTES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_STORE = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]               state_q;
	logic                     asm_q;
	frp_pkg::frame_idx_t      prev_q;
	frp_pkg::seq_id_t         seq_q;
	logic [7:0]               rem_q;
	logic [7:0]               len_q;
	logic [7:0]               pos_q;
	logic [2:0]               cnt_q;
	logic [4:0]               k_q;
	frp_pkg::octet_t          pay_q [frp_pkg::NEXT_FRAME_BYTES];
	logic [63:0]              mem_q [ROWS];

	logic                     v_s1;
	logic [4:0]               k_s1;
	logic [63:0]              rd_s1;

	frp_pkg::frame_idx_t      in_idx;
	frp_pkg::seq_id_t         in_id;
	logic                     accept;
	logic                     step_ok;
	logic [7:0]               rem_d;
	logic [4:0]               last_k;
	logic [8:0]               left9;
	logic [3:0]               nbytes;

	assign in_idx = header_byte[frp_pkg::IDX_W-1:0];
	assign in_id  = header_byte[7:frp_pkg::IDX_W];
	assign busy   = (state_q != ST_IDLE) || v_s1;
	assign accept = start && !busy;

	assign step_ok = (state_q == ST_STORE) && (rem_q != 8'd0) && ({1'b0, pos_q} < BUF_LIM);
	assign rem_d   = step_ok ? rem_q - 8'd1 : rem_q;
	assign last_k  = (len_q == 8'd0) ? 5'd0 : 5'((len_q - 8'd1) >> 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			asm_q   <= 1'b0;
			prev_q  <= '0;
			seq_q   <= '0;
			rem_q   <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!asm_q) begin
							if (in_idx == '0) begin
								seq_q   <= in_id;
								len_q   <= data_byte_1;
								rem_q   <= data_byte_1;
								pos_q   <= 8'd0;
								cnt_q   <= 3'(frp_pkg::FIRST_FRAME_BYTES);
								prev_q  <= '0;
								asm_q   <= 1'b1;
								state_q <= ST_STORE;
							end
						end else if (in_id == seq_q &&
						             {1'b0, in_idx} == {1'b0, prev_q} + 6'd1) begin
							pos_q   <= {in_idx, 3'b000} - {3'b000, in_idx} - 8'd1;
							cnt_q   <= 3'(frp_pkg::NEXT_FRAME_BYTES);
							prev_q  <= in_idx;
							state_q <= ST_STORE;
						end
					end
				end
				ST_STORE: begin
					rem_q <= rem_d;
					pos_q <= pos_q + 8'd1;
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == 3'd1) begin
						if (rem_d == 8'd0) begin
							asm_q   <= 1'b0;
							k_q     <= 5'd0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					v_s1 <= 1'b1;
					k_q  <= k_q + 5'd1;
					if (k_q == last_k) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// frame payload, consumed from the bottom one byte per store cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!asm_q) begin
				pay_q[0] <= data_byte_2;
				pay_q[1] <= data_byte_3;
				pay_q[2] <= data_byte_4;
				pay_q[3] <= data_byte_5;
				pay_q[4] <= data_byte_6;
				pay_q[5] <= data_byte_7;
				pay_q[6] <= 8'd0;
			end else begin
				pay_q[0] <= data_byte_1;
				pay_q[1] <= data_byte_2;
				pay_q[2] <= data_byte_3;
				pay_q[3] <= data_byte_4;
				pay_q[4] <= data_byte_5;
				pay_q[5] <= data_byte_6;
				pay_q[6] <= data_byte_7;
			end
		end else if (state_q == ST_STORE) begin
			for (int i = 0; i < frp_pkg::NEXT_FRAME_BYTES - 1; i++) begin
				pay_q[i] <= pay_q[i+1];
			end
		end
	end

	// packet buffer: 8-byte rows, byte-lane writes, one row read per cycle
	always_ff @(posedge clk) begin
		if (step_ok) begin
			mem_q[pos_q[ROW_AW+2:3]][{pos_q[2:0], 3'b000} +: 8] <= pay_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			rd_s1 <= mem_q[k_q[ROW_AW-1:0]];
			k_s1  <= k_q;
		end
	end

	assign left9  = {1'b0, len_q} - {1'b0, k_s1, 3'b000};
	assign nbytes = (left9 > 9'd8) ? 4'd8 : left9[3:0];

	always_comb begin
		for (int b = 0; b < frp_pkg::WORD_BYTES; b++) begin
			word_data[b*8 +: 8] = (4'(b) < nbytes) ? rd_s1[b*8 +: 8] : 8'd0;
		end
	end

	assign word_strobe   = v_s1;
	assign word_bytes    = nbytes;
	assign packet_length = len_q;
	assign last_word     = (k_s1 == last_k);

`ifndef ASSERT_OFF
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		word_strobe && last_word |=> !word_strobe)
		else $error("word after last word");

	a_words_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		word_strobe && !last_word |=> word_strobe)
		else $error("gap inside packet");

	a_accept_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !word_strobe)
		else $error("word right after frame transfer");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		word_strobe && word_bytes == 4'd0 |-> last_word && word_data == 64'd0
		&& packet_length == 8'd0)
		else $error("bad empty word");

	a_emit_not_asm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !asm_q && rem_q == 8'd0)
		else $error("emitting while assembling");
`endif

endmodule

// File: tb/fast_packet_reassembler_tb.sv
`timescale 1ns / 1ps

module fast_packet_reassembler_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PACKET  = frp_pkg::FIRST_FRAME_BYTES + 31 * frp_pkg::NEXT_FRAME_BYTES;

	typedef struct {
		logic [63:0]     data;
		logic [3:0]      nbytes;
		frp_pkg::octet_t len;
		logic            last;
	} out_word_t;

	class reassembly_model;
		out_word_t           pending_words[$];
		frp_pkg::octet_t     pkt_bytes[frp_pkg::BUFFER_BYTES_DEF];
		logic                assembling;
		frp_pkg::frame_idx_t prev_idx;
		frp_pkg::seq_id_t    seq;
		frp_pkg::octet_t     remaining;
		frp_pkg::octet_t     declared;
		int                  errors;
		int                  frames_taken;
		int                  packets_done;
		int                  words_checked;

		function new();
			assembling    = 1'b0;
			prev_idx      = '0;
			seq           = '0;
			remaining     = '0;
			declared      = '0;
			errors        = 0;
			frames_taken  = 0;
			packets_done  = 0;
			words_checked = 0;
		endfunction

		function void store(int pos, frp_pkg::octet_t v);
			if (remaining == 0 || pos >= frp_pkg::BUFFER_BYTES_DEF)
				return;
			pkt_bytes[pos] = v;
			remaining--;
		endfunction

		function void emit();
			out_word_t w;
			int len;
			int words;
			int n;
			len = int'(declared);
			words = (len + frp_pkg::WORD_BYTES - 1) / frp_pkg::WORD_BYTES;
			packets_done++;
			if (words == 0) begin
				w.data   = '0;
				w.nbytes = '0;
				w.len    = '0;
				w.last   = 1'b1;
				pending_words.push_back(w);
				return;
			end
			for (int k = 0; k < words; k++) begin
				n = len - frp_pkg::WORD_BYTES * k;
				if (n > frp_pkg::WORD_BYTES)
					n = frp_pkg::WORD_BYTES;
				w.data = '0;
				for (int b = 0; b < n; b++)
					w.data[8*b +: 8] = pkt_bytes[frp_pkg::WORD_BYTES * k + b];
				w.nbytes = n[3:0];
				w.len    = declared;
				w.last   = (k == words - 1);
				pending_words.push_back(w);
			end
		endfunction

		function void note_frame(logic [63:0] fr);
			frp_pkg::frame_idx_t idx;
			frp_pkg::seq_id_t    id;
			idx = fr[frp_pkg::IDX_W-1:0];
			id  = fr[7:8-frp_pkg::ID_W];
			if (!assembling) begin
				if (idx != 0)
					return;
				seq       = id;
				declared  = fr[15:8];
				remaining = fr[15:8];
				for (int i = 0; i < frp_pkg::FIRST_FRAME_BYTES; i++)
					store(i, fr[8*(i+2) +: 8]);
				prev_idx   = '0;
				assembling = 1'b1;
			end else begin
				if (id != seq || int'(idx) != int'(prev_idx) + 1)
					return;
				for (int i = 0; i < frp_pkg::NEXT_FRAME_BYTES; i++)
					store(int'(idx) * frp_pkg::NEXT_FRAME_BYTES - 1 + i, fr[8*(i+1) +: 8]);
				prev_idx = idx;
			end
			frames_taken++;
			if (remaining != 0)
				return;
			assembling = 1'b0;
			emit();
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			words_checked++;
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got data %h bytes %0d",
					$time, got.data, got.nbytes);
				return;
			end
			want = pending_words.pop_front();
			if (got.data !== want.data) begin
				errors++;
				$display("%0t: word_data expected %h got %h", $time, want.data, got.data);
			end
			if (got.nbytes !== want.nbytes) begin
				errors++;
				$display("%0t: word_bytes expected %0d got %0d", $time, want.nbytes, got.nbytes);
			end
			if (got.len !== want.len) begin
				errors++;
				$display("%0t: packet_length expected %0d got %0d", $time, want.len, got.len);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last_word expected %b got %b", $time, want.last, got.last);
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  header_byte;
	logic [7:0]  data_byte_1;
	logic [7:0]  data_byte_2;
	logic [7:0]  data_byte_3;
	logic [7:0]  data_byte_4;
	logic [7:0]  data_byte_5;
	logic [7:0]  data_byte_6;
	logic [7:0]  data_byte_7;
	logic        word_strobe;
	logic [63:0] word_data;
	logic [3:0]  word_bytes;
	logic [7:0]  packet_length;
	logic        last_word;

	reassembly_model model;
	out_word_t       seen_word;
	int              idle_pct;
	int              items;
	int              stall_cycles;

	fast_packet_reassembler uut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (word_strobe) begin
				seen_word.data   = word_data;
				seen_word.nbytes = word_bytes;
				seen_word.len    = packet_length;
				seen_word.last   = last_word;
				model.check_word(seen_word);
			end
			if (start && !busy)
				model.note_frame({data_byte_7, data_byte_6, data_byte_5, data_byte_4,
					data_byte_3, data_byte_2, data_byte_1, header_byte});
			if (word_strobe || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic drive_frame(input logic [63:0] fr);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		{data_byte_7, data_byte_6, data_byte_5, data_byte_4,
			data_byte_3, data_byte_2, data_byte_1, header_byte} <= fr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// fill < 0 gives random payload, else every payload byte is fill
	task automatic send_packet(input frp_pkg::seq_id_t id, input int len, input int noise_pct,
			input int fill);
		logic [63:0] payload;
		logic [4:0]  bad_idx;
		int          n_frames;
		n_frames = (len <= frp_pkg::FIRST_FRAME_BYTES) ? 1 :
			1 + (len - frp_pkg::FIRST_FRAME_BYTES + frp_pkg::NEXT_FRAME_BYTES - 1) /
			frp_pkg::NEXT_FRAME_BYTES;
		if (n_frames > 32)
			n_frames = 32;
		for (int f = 0; f < n_frames; f++) begin
			if ($urandom_range(99) < noise_pct) begin
				payload = {$urandom, $urandom};
				bad_idx = 5'(f + $urandom_range(1, 31));
				if (f == 0)
					drive_frame({payload[63:8],
						$urandom_range(7, 0) == 0 ? id : frp_pkg::seq_id_t'($urandom),
						bad_idx});
				else case ($urandom_range(2))
					0: drive_frame({payload[63:8], frp_pkg::seq_id_t'(id ^ $urandom_range(1, 7)),
						5'(f)});
					1: drive_frame({payload[63:8], id, bad_idx});
					default: drive_frame({payload[63:8], id, 5'd0});
				endcase
			end
			payload = (fill < 0) ? {$urandom, $urandom} : {8{fill[7:0]}};
			if (f == 0)
				drive_frame({payload[63:16], 8'(len), id, 5'd0});
			else
				drive_frame({payload[63:8], id, 5'(f)});
			items++;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (model.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int target);
		int first;
		int r;
		int len;
		first = items;
		while (items - first < target) begin
			r = $urandom_range(99);
			if (r < 10)
				len = $urandom_range(frp_pkg::FIRST_FRAME_BYTES, 0);
			else if (r < 85)
				len = $urandom_range(40, 7);
			else if (r < 97)
				len = $urandom_range(120, 41);
			else
				len = $urandom_range(MAX_PACKET, 121);
			if ($urandom_range(99) < 15)
				drive_frame({32'($urandom), 24'($urandom),
					frp_pkg::seq_id_t'($urandom), 5'($urandom_range(31, 1))});
			send_packet(frp_pkg::seq_id_t'($urandom), len, 20, -1);
		end
		drain();
	endtask

	initial begin
		model        = new();
		idle_pct     = 37;
		items        = 0;
		stall_cycles = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		{data_byte_7, data_byte_6, data_byte_5, data_byte_4,
			data_byte_3, data_byte_2, data_byte_1, header_byte} = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray, empty, single-frame, two-frame and three-frame packets
		drive_frame({56'h0, 3'd2, 5'd5});
		send_packet(3'd1, 0, 0, -1);
		send_packet(3'd0, 1, 0, 8'hff);
		send_packet(3'd6, 6, 0, 8'hff);
		drive_frame({48'hffff_ffff_ffff, 8'd7, 3'd7, 5'd0});
		drive_frame({56'h1122_3344_5566_77, 3'd3, 5'd1});
		drive_frame({48'h0, 8'd2, 3'd7, 5'd0});
		drive_frame({56'h0, 3'd7, 5'd2});
		drive_frame({56'ha5a5_a5a5_a5a5_a5, 3'd7, 5'd1});
		send_packet(3'd4, 8, 0, 8'h00);
		send_packet(3'd5, 9, 0, -1);
		send_packet(3'd3, 16, 0, -1);
		drain();

		run_random(10);
		idle_pct = 71;
		run_random(10);
		idle_pct = 0;
		send_packet(frp_pkg::seq_id_t'($urandom), MAX_PACKET, 0, -1);
		drain();

		// over-long packet runs out of frame indexes and never completes
		send_packet(3'd6, 240, 10, -1);
		repeat (4)
			drive_frame({$urandom, $urandom});
		drain();
		repeat (48) @(posedge clk);

		$display("Run: %0d frames taken, %0d packets completed, %0d words checked",
			model.frames_taken, model.packets_done, model.words_checked);
		$display("Covered empty, one-frame, full-length and unfinishable packets with noise frames");
		if (model.errors == 0 && model.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
